// ===== sv/scc_pkg.sv =====
// Shared commands and types for the strongly connected component counter.
`default_nettype none
package scc_pkg;
    localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [1:0] CMD_RUN      = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    localparam int COUNT_W = 9;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
    } scc_result_t;
endpackage
`default_nettype wire

// ===== sv/scc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                                       clk,
    input  wire                                       we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                          wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/scc_dfs.sv =====
// Depth-first search sequencer that runs both passes of the component count.
`default_nettype none
module scc_dfs #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  wire                                              clk,
    input  wire                                              rst_n,
    input  wire                                              start,
    input  wire  [$clog2(MAX_NODES+1)-1:0]                   live_nodes,
    input  wire  [$clog2(MAX_EDGES+1)-1:0]                   edge_total,
    output logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_raddr,
    input  wire  [2*$clog2(MAX_NODES)-1:0]                   edge_rdata,
    output scc_pkg::scc_result_t                             result
);
    import scc_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES+1);
    localparam int TW  = $clog2(MAX_EDGES+1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CLR       = 4'd1;
    localparam logic [3:0] S_OUTER     = 4'd2;
    localparam logic [3:0] S_OUTER_CHK = 4'd3;
    localparam logic [3:0] S_EDGE_RD   = 4'd4;
    localparam logic [3:0] S_EDGE_CHK  = 4'd5;
    localparam logic [3:0] S_VIS_CHK   = 4'd6;
    localparam logic [3:0] S_STK_WAIT  = 4'd7;
    localparam logic [3:0] S_POP       = 4'd8;
    localparam logic [3:0] S_POP_WAIT  = 4'd9;
    localparam logic [3:0] S_POP_CHK   = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic               pass2_reg, pass2_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      sp_reg, sp_next;
    logic [CW-1:0]      fd_reg, fd_next;
    logic [NW-1:0]      cur_reg, cur_next;
    logic [NW-1:0]      b_reg, b_next;
    logic [TW-1:0]      cursor_reg, cursor_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               vis_we, vis_wdata, vis_rdata;
    logic [NW-1:0]      vis_waddr, vis_raddr;
    logic               stk_we;
    logic [NW-1:0]      stk_waddr, stk_raddr;
    logic [NW+TW-1:0]   stk_wdata, stk_rdata;
    logic               fin_we;
    logic [NW-1:0]      fin_waddr, fin_raddr, fin_rdata;
    logic [NW-1:0]      edge_a, edge_b;

    scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );
    scc_ram #(.WIDTH(NW+TW), .DEPTH(MAX_NODES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_finish (
        .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(cur_reg),
        .raddr(fin_raddr), .rdata(fin_rdata)
    );

    // Second pass walks every edge reversed.
    assign edge_a = pass2_reg ? edge_rdata[NW-1:0] : edge_rdata[2*NW-1:NW];
    assign edge_b = pass2_reg ? edge_rdata[2*NW-1:NW] : edge_rdata[NW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        pass2_next  = pass2_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        sp_next     = sp_reg;
        fd_next     = fd_reg;
        cur_next    = cur_reg;
        b_next      = b_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        vis_we      = 1'b0;
        vis_waddr   = idx_reg[NW-1:0];
        vis_wdata   = 1'b0;
        vis_raddr   = idx_reg[NW-1:0];
        stk_we      = 1'b0;
        stk_waddr   = sp_reg[NW-1:0];
        stk_wdata   = {cur_reg, cursor_reg + TW'(1)};
        stk_raddr   = sp_reg[NW-1:0] - NW'(1);
        fin_we      = 1'b0;
        fin_waddr   = fd_reg[NW-1:0];
        fin_raddr   = fd_reg[NW-1:0] - NW'(1);
        edge_raddr  = cursor_reg[EAW-1:0];
        result      = '{done: 1'b0, count: count_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = live_nodes;
                    pass2_next = 1'b0;
                    idx_next   = '0;
                    fd_next    = '0;
                    count_next = '0;
                    if (live_nodes == '0)
                    begin
                        result = '{done: 1'b1, count: '0};
                    end
                    else
                    begin
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                vis_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (idx_reg == n_reg - CW'(1))
                begin
                    idx_next   = '0;
                    state_next = pass2_reg ? S_POP : S_OUTER;
                end
            end
            S_OUTER:
            begin
                if (idx_reg == n_reg)
                begin
                    pass2_next = 1'b1;
                    idx_next   = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_OUTER_CHK;
                end
            end
            S_OUTER_CHK:
            begin
                if (!vis_rdata)
                begin
                    vis_we      = 1'b1;
                    vis_wdata   = 1'b1;
                    cur_next    = idx_reg[NW-1:0];
                    cursor_next = '0;
                    sp_next     = '0;
                    state_next  = S_EDGE_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_OUTER;
                end
            end
            S_EDGE_RD:
            begin
                if (cursor_reg >= edge_total)
                begin
                    // Node finished.
                    if (!pass2_reg)
                    begin
                        fin_we  = 1'b1;
                        fd_next = fd_reg + CW'(1);
                    end
                    if (sp_reg == '0)
                    begin
                        if (pass2_reg)
                        begin
                            state_next = S_POP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = S_OUTER;
                        end
                    end
                    else
                    begin
                        sp_next    = sp_reg - CW'(1);
                        state_next = S_STK_WAIT;
                    end
                end
                else
                begin
                    state_next = S_EDGE_CHK;
                end
            end
            S_EDGE_CHK:
            begin
                vis_raddr = edge_b;
                b_next    = edge_b;
                if (edge_a == cur_reg && CW'(edge_b) < n_reg && CW'(edge_a) < n_reg)
                begin
                    state_next = S_VIS_CHK;
                end
                else
                begin
                    cursor_next = cursor_reg + TW'(1);
                    state_next  = S_EDGE_RD;
                end
            end
            S_VIS_CHK:
            begin
                if (!vis_rdata)
                begin
                    vis_we      = 1'b1;
                    vis_waddr   = b_reg;
                    vis_wdata   = 1'b1;
                    stk_we      = 1'b1;
                    sp_next     = sp_reg + CW'(1);
                    cur_next    = b_reg;
                    cursor_next = '0;
                end
                else
                begin
                    cursor_next = cursor_reg + TW'(1);
                end
                state_next = S_EDGE_RD;
            end
            S_STK_WAIT:
            begin
                cur_next    = stk_rdata[NW+TW-1:TW];
                cursor_next = stk_rdata[TW-1:0];
                state_next  = S_EDGE_RD;
            end
            S_POP:
            begin
                if (fd_reg == '0)
                begin
                    result     = '{done: 1'b1, count: count_reg};
                    state_next = S_IDLE;
                end
                else
                begin
                    fd_next    = fd_reg - CW'(1);
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                vis_raddr  = fin_rdata;
                cur_next   = fin_rdata;
                state_next = S_POP_CHK;
            end
            S_POP_CHK:
            begin
                if (!vis_rdata)
                begin
                    // Unvisited node on the finish stack opens a new component.
                    vis_we      = 1'b1;
                    vis_waddr   = cur_reg;
                    vis_wdata   = 1'b1;
                    count_next  = count_reg + COUNT_W'(1);
                    cursor_next = '0;
                    sp_next     = '0;
                    state_next  = S_EDGE_RD;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass2_reg  <= pass2_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        sp_reg     <= sp_next;
        fd_reg     <= fd_next;
        cur_reg    <= cur_next;
        b_reg      <= b_next;
        cursor_reg <= cursor_next;
        count_reg  <= count_next;
    end
endmodule
`default_nettype wire

// ===== sv/strongly_connected_component_count.sv =====
// Top level of the strongly connected component counter.
`default_nettype none
// Counts the strongly connected components of a directed graph by Kosaraju's
// method. Each input item carries a command: add an edge, run the count, or
// clear all edges. An add or clear item yields no result item, so edges can
// stream in back to back. A run item yields one result item holding the
// component count and the sticky edge overflow flag. Edges whose endpoints
// fall outside 1..node_count are dropped; edges beyond MAX_EDGES are dropped
// and set the overflow flag, which only a clear item or a reset clears.
// Each of the two passes of a run scans the edge memory once from every node
// it visits, through one memory port, plus a visited check for each edge
// that leaves the node being searched. The rest of a run goes to sweeping
// the visited marks clear before each pass, to the node loop of the first
// pass and to popping the finish stack in the second.
// The input is not ready while a run is in progress or its result waits to
// be taken. Write node_count only while the block is idle.
module strongly_connected_component_count #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [8:0]  cfg_data,       // node_count
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // command[1:0], from_node[10:2], to_node[19:11]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // component_count[8:0], edge_overflow[9]
);
    import scc_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES+1);
    localparam int TW  = $clog2(MAX_EDGES+1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    logic [8:0]         node_count_reg;
    logic [TW-1:0]      edge_total_reg;
    logic               overflow_reg;
    logic               busy_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_overflow_reg;

    logic [1:0]         command;
    logic [8:0]         from_node, to_node;
    logic [CW-1:0]      live_nodes;
    logic               in_accept, edge_ok, edge_we, run_start;
    logic [EAW-1:0]     edge_raddr;
    logic [2*NW-1:0]    edge_rdata;
    scc_result_t        result;

    assign command   = s_axis_tdata[1:0];
    assign from_node = s_axis_tdata[10:2];
    assign to_node   = s_axis_tdata[19:11];

    // Node counts above the store's capacity behave as the capacity.
    assign live_nodes = (32'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES)
                                                          : CW'(node_count_reg);

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg && !out_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign edge_ok = (from_node != 9'd0) && (to_node != 9'd0)
                  && (32'(from_node) <= 32'(live_nodes))
                  && (32'(to_node) <= 32'(live_nodes));
    assign edge_we   = in_accept && (command == CMD_ADD_EDGE) && edge_ok
                    && (32'(edge_total_reg) < MAX_EDGES);
    assign run_start = in_accept && (command == CMD_RUN);

    scc_ram #(.WIDTH(2*NW), .DEPTH(MAX_EDGES)) u_edges (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_total_reg[EAW-1:0]),
        .wdata ({NW'(from_node - 9'd1), NW'(to_node - 9'd1)}),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    scc_dfs #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dfs (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (run_start),
        .live_nodes (live_nodes),
        .edge_total (edge_total_reg),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .result     (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_overflow_reg, out_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 9'd1;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
            if (edge_we)
            begin
                edge_total_reg <= edge_total_reg + TW'(1);
            end
            if (in_accept && (command == CMD_ADD_EDGE) && edge_ok && !edge_we)
            begin
                overflow_reg <= 1'b1;
            end
            if (in_accept && (command == CMD_CLEAR))
            begin
                edge_total_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            if (run_start)
            begin
                busy_reg <= 1'b1;
            end
            if (result.done)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            out_count_reg    <= result.count;
            out_overflow_reg <= overflow_reg;
        end
    end
endmodule
`default_nettype wire
